[src/rfp_pkg.sv]
// Shared types and constants for the rangefinder frame parser.
`default_nettype none
package rfp_pkg;

  // Frame header value, sent twice at the start of each frame
  localparam logic [7:0]  HeaderByte = 8'h59;
  // Distance code that means no reading
  localparam logic [15:0] NoReading  = 16'hFFFF;

  // One parsed result beat
  typedef struct packed {
    logic [15:0] distance_cm;
    logic        distance_valid;
  } rfp_result_t;

endpackage
`default_nettype wire

[src/rfp_parser.sv]
// Byte-wise frame state machine: header hunt, field capture, checksum check.
`default_nettype none
module rfp_parser
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  output rfp_result_t      res_o
);

  // Frame phase codes
  localparam logic [3:0] PhHunt   = 4'd0;
  localparam logic [3:0] PhHdr1   = 4'd1;
  localparam logic [3:0] PhHdr2   = 4'd2;
  localparam logic [3:0] PhDistLo = 4'd3;
  localparam logic [3:0] PhDistHi = 4'd4;
  localparam logic [3:0] PhStrLo  = 4'd5;
  localparam logic [3:0] PhStrHi  = 4'd6;
  localparam logic [3:0] PhResvd  = 4'd7;
  localparam logic [3:0] PhQual   = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] dist_lo_q, dist_lo_d;
  logic [7:0] dist_hi_q, dist_hi_d;
  logic [7:0] sum_add;

  assign sum_add = sum_q + rx_byte_i;

  // Next-state logic for one received byte
  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    dist_lo_d   = dist_lo_q;
    dist_hi_d   = dist_hi_q;
    res_valid_o = 1'b0;
    res_o.distance_cm    = {dist_hi_q, dist_lo_q};
    res_o.distance_valid = ({dist_hi_q, dist_lo_q} != NoReading);
    if (byte_en_i) begin
      case (phase_q)
        PhHdr1: begin
          if (rx_byte_i == HeaderByte) begin
            sum_d   = sum_add;
            phase_d = PhHdr2;
          end else begin
            sum_d   = 8'd0;
            phase_d = PhHunt;
          end
        end
        PhHdr2: begin
          dist_lo_d = rx_byte_i;
          sum_d     = sum_add;
          phase_d   = PhDistLo;
        end
        PhDistLo: begin
          dist_hi_d = rx_byte_i;
          sum_d     = sum_add;
          phase_d   = PhDistHi;
        end
        PhDistHi, PhStrLo, PhStrHi, PhResvd: begin
          sum_d   = sum_add;
          phase_d = phase_q + 4'd1;
        end
        PhQual: begin
          // checksum byte closes the frame either way
          res_valid_o = (rx_byte_i == sum_q);
          sum_d       = 8'd0;
          phase_d     = PhHunt;
        end
        default: begin
          // hunting, and unused codes behave as hunting
          if (rx_byte_i == HeaderByte) begin
            sum_d   = rx_byte_i;
            phase_d = PhHdr1;
          end else begin
            sum_d   = 8'd0;
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      sum_q     <= 8'd0;
      dist_lo_q <= 8'd0;
      dist_hi_q <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      dist_lo_q <= dist_lo_d;
      dist_hi_q <= dist_hi_d;
    end
  end

endmodule
`default_nettype wire

[src/rfp_out_buf.sv]
// Two-entry result buffer: output register plus skid slot.
`default_nettype none
module rfp_out_buf
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire rfp_result_t push_data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rfp_result_t      out_data_o
);

  logic [1:0]  count_q, count_d;
  rfp_result_t ent0_q, ent0_d;
  rfp_result_t ent1_q, ent1_d;
  logic        pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = ent0_q;
  assign space_o     = (count_q != 2'd2);
  assign pop         = out_valid_o && out_ready_i;

  // Shift-style queue update
  always_comb begin
    count_d = count_q;
    ent0_d  = ent0_q;
    ent1_d  = ent1_q;
    if (pop && push_i) begin
      if (count_q == 2'd1) begin
        ent0_d = push_data_i;
      end else begin
        ent0_d = ent1_q;
        ent1_d = push_data_i;
      end
    end else if (pop) begin
      ent0_d  = ent1_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        ent0_d = push_data_i;
      end else begin
        ent1_d = push_data_i;
      end
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule
`default_nettype wire

[src/rangefinder_frame_parser_unit.sv]
// Top level of the rangefinder frame parser.
// A result appears on out_valid_o in the cycle after its checksum beat is taken.
// Throughput: one byte beat per cycle; the two-entry result buffer keeps the
// input open while one result waits, and closes it only when both entries are full.
// Reset (rst_ni low, asynchronous): parser returns to header hunt with zero sum
// and zero distance bytes; the result buffer is emptied.
`default_nettype none
module rangefinder_frame_parser_unit
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      distance_cm_o,
  output logic             distance_valid_o
);

  logic        byte_en;
  logic        res_valid;
  logic        space;
  rfp_result_t res;
  rfp_result_t out_data;

  assign in_ready_o = space;
  assign byte_en    = in_valid_i && space;

  // Frame state machine
  rfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (byte_en),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register with skid slot
  rfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign distance_cm_o    = out_data.distance_cm;
  assign distance_valid_o = out_data.distance_valid;

endmodule
`default_nettype wire

[test/rangefinder_frame_parser_unit_test.sv]
// Self-checking testbench for the rangefinder frame parser: byte stream in, distance beats out.
`timescale 1ns / 100ps
module rangefinder_frame_parser_unit_test;
  import rfp_pkg::*;

  // Parser position, named after the last byte taken
  typedef enum logic [3:0] {
    PH_HUNT, PH_HEAD1, PH_HEAD2, PH_DIST_LO, PH_DIST_HI,
    PH_STR_LO, PH_STR_HI, PH_RESERVED, PH_QUALITY
  } frame_phase_e;

  // Tracks the frame parser byte by byte and holds the distance beats still due
  class distance_checker;
    frame_phase_e  phase;
    logic [7:0]    frame_sum;
    logic [7:0]    dist_lo;
    logic [7:0]    dist_hi;
    rfp_result_t   readings_due[$];
    int unsigned   mismatches;

    function new();
      phase      = PH_HUNT;
      frame_sum  = 8'h00;
      dist_lo    = 8'h00;
      dist_hi    = 8'h00;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Advance the parser on one accepted byte beat
    function void take_byte(logic [7:0] b);
      rfp_result_t reading;
      case (phase)
        PH_HEAD1: begin
          if (b == HeaderByte) begin
            frame_sum += b;
            phase = PH_HEAD2;
          end else begin
            // bad second header; this byte is not retried as a first header
            frame_sum = 8'h00;
            phase = PH_HUNT;
          end
        end
        PH_HEAD2: begin
          dist_lo = b;
          frame_sum += b;
          phase = PH_DIST_LO;
        end
        PH_DIST_LO: begin
          dist_hi = b;
          frame_sum += b;
          phase = PH_DIST_HI;
        end
        PH_DIST_HI, PH_STR_LO, PH_STR_HI, PH_RESERVED: begin
          frame_sum += b;
          phase = frame_phase_e'(phase + 1);
        end
        PH_QUALITY: begin
          if (b == frame_sum) begin
            reading.distance_cm    = {dist_hi, dist_lo};
            reading.distance_valid = ({dist_hi, dist_lo} != NoReading);
            readings_due.push_back(reading);
          end
          frame_sum = 8'h00;
          phase = PH_HUNT;
        end
        default: begin
          if (b == HeaderByte) begin
            frame_sum = b;
            phase = PH_HEAD1;
          end else begin
            frame_sum = 8'h00;
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest reading due
    function void check_reading(logic [15:0] dist_cm, logic dist_ok);
      rfp_result_t want;
      if (readings_due.size() == 0) begin
        report($sformatf("unexpected reading distance=%h valid=%b", dist_cm, dist_ok));
        return;
      end
      want = readings_due.pop_front();
      if (dist_cm !== want.distance_cm)
        report($sformatf("distance_cm exp %h got %h", want.distance_cm, dist_cm));
      if (dist_ok !== want.distance_valid)
        report($sformatf("distance_valid exp %b got %b", want.distance_valid, dist_ok));
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] distance_cm;
  logic        distance_valid;

  bit          no_idle    = 1'b0;
  int unsigned bytes_sent = 0;
  distance_checker chk;

  rangefinder_frame_parser_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .distance_cm_o    (distance_cm),
    .distance_valid_o (distance_valid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Send one byte beat, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    chk.take_byte(b);
    bytes_sent++;
  endtask

  // Full frame; a nonzero skew corrupts the checksum byte
  task automatic send_frame(input logic [15:0] dist_cm, input logic [7:0] skew);
    logic [7:0] body [8];
    logic [7:0] sum;
    body[0] = HeaderByte;
    body[1] = HeaderByte;
    body[2] = dist_cm[7:0];
    body[3] = dist_cm[15:8];
    for (int i = 4; i < 8; i++) body[i] = 8'($urandom_range(0, 255));
    sum = 8'h00;
    for (int i = 0; i < 8; i++) begin
      sum += body[i];
      send_byte(body[i]);
    end
    send_byte(sum + skew);
  endtask

  // Hold off the sender until every reading due has come out
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.readings_due.size() != 0);
  endtask

  // Result side: check beats, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) chk.check_reading(distance_cm, distance_valid);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && rst_n && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned pick;
    logic [15:0] dist_cm;
    logic [7:0]  other;
    chk = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: noise, bad second header, no-reading frame, header-valued data, bad checksum
    send_byte(8'h00);
    send_byte(HeaderByte);
    send_byte(8'hA6);
    send_frame(16'hFFFF, 8'h00);
    send_frame(16'h5959, 8'h00);
    send_frame(16'h0000, 8'h01);

    // random: mostly well-formed frames, some noise and broken frames
    while (bytes_sent < 1900) begin
      if (bytes_sent >= 1600) no_idle = 1'b1;
      if (bytes_sent >= 900 && bytes_sent < 915) drain_readings();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 7))
          0:       dist_cm = 16'h0000;
          1:       dist_cm = 16'hFFFF;
          2:       dist_cm = 16'hFFFE;
          3:       dist_cm = {HeaderByte, HeaderByte};
          default: dist_cm = 16'($urandom_range(0, 16'hFFFF));
        endcase
        send_frame(dist_cm,
                   ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 3) == 0) ? HeaderByte : 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        other = 8'($urandom_range(0, 255));
        if (other == HeaderByte) other = ~other;
        send_byte(HeaderByte);
        send_byte(other);
      end else begin
        // frame cut short; following bytes land mid-frame
        send_byte(HeaderByte);
        send_byte(HeaderByte);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    drain_readings();
    repeat (8) @(posedge clk);
    if (chk.mismatches == 0 && chk.readings_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
src/rfp_pkg.sv
src/rfp_parser.sv
src/rfp_out_buf.sv
src/rangefinder_frame_parser_unit.sv
test/rangefinder_frame_parser_unit_test.sv
